// ----- src/sfr_pkg.sv -----
// Shared constants, register codes and the job record for the stream find/replace block.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int WIN_DEPTH  = 8;
    localparam int WIN_IDX_W  = 3;
    localparam int WIN_W      = WIN_DEPTH * BYTE_W;
    localparam int LEN_W      = 4;
    localparam int LIMIT_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int QUEUE_DEPTH         = 4;
    localparam int DEF_MAX_PATTERN     = 8;
    localparam int DEF_MAX_REPLACEMENT = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_REPLACE_LIMIT      = 3'd4
    } cfg_reg_t;

    // One job from front to back: up to eight bytes to send, plus string end.
    // A job with count zero and last set is the empty end marker.
    typedef struct packed {
        logic [WIN_W-1:0] bytes;
        logic [LEN_W-1:0] count;
        logic             last;
    } job_t;

endpackage

`default_nettype wire

// ----- src/sfr_ifs.sv -----
// Valid/ready channel interfaces: input bytes, result bytes, configuration writes.
`default_nettype none

interface sfr_in_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid_byte;
    logic              out_last;
    modport source (output valid, output out_byte, output out_valid_byte,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_valid_byte,
                    input out_last, output ready);
endinterface

interface sfr_cfg_if;
    import sfr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/stream_find_replace_top.sv -----
// Top level of the streaming substring find-and-replace block.
//
//  channel     dir  payload                              transfer when
//  in_stream   in   in_byte[7:0], in_last                valid && ready
//  out_stream  out  out_byte[7:0], out_valid_byte, last  valid && ready
//  cfg         in   index[2:0], data[63:0]               valid && ready (ready is 1)
//
// The front takes one byte per cycle while the four-entry job queue has room.
// Each byte makes zero to eight results; the back sends one result per cycle
// while out_stream.ready is high.
// A first result passes the job queue and the output register before it can transfer.
// Reset clears window, queue and output register; no clearing pass.
// A stalled output fills the queue, and then in_stream.ready drops.
`default_nettype none

module stream_find_replace_top #(
    parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
    input  logic       clk,
    input  logic       rst_n,
    sfr_in_if.sink     in_stream,
    sfr_out_if.source  out_stream,
    sfr_cfg_if.sink    cfg
);
    import sfr_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t q_job;
    job_t q_head;

    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head),
        .pop      (q_pop)
    );

    sfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_stream (out_stream)
    );

    // Queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    // Queue never read when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue underflow");

    // An empty marker only ever closes a string
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_stream.valid && !out_stream.out_valid_byte) |-> out_stream.out_last)
        else $error("end marker without last flag");

endmodule

`default_nettype wire

// ----- src/sfr_front.sv -----
// Front end: config registers, byte window, match decision, job generation.
`default_nettype none

module sfr_front #(
    parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
    input  logic           clk,
    input  logic           rst_n,
    sfr_in_if.sink         in_stream,
    sfr_cfg_if.sink        cfg,
    input  logic           q_full,
    output logic           q_push,
    output sfr_pkg::job_t  q_job
);
    import sfr_pkg::*;

    localparam int PL_CAP = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
    localparam int RL_CAP = (MAX_REPLACEMENT < WIN_DEPTH) ? MAX_REPLACEMENT : WIN_DEPTH;

    // Configuration registers
    logic [WIN_W-1:0]          pat_bytes_reg;
    logic [LEN_W-1:0]          pat_len_reg;
    logic [WIN_W-1:0]          rep_bytes_reg;
    logic [LEN_W-1:0]          rep_len_reg;
    logic signed [LIMIT_W-1:0] limit_reg;

    // Window state
    logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_reg, win_next;
    logic [LEN_W-1:0]                 fill_reg, fill_next;
    logic signed [LIMIT_W-1:0]        left_reg, left_next;
    logic                             in_string_reg;

    logic [LEN_W-1:0]                 pl, rl;
    logic [LEN_W-1:0]                 fill_eff, fill_ins;
    logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_ins;
    logic signed [LIMIT_W-1:0]        left_start;
    logic                             active;
    logic                             match;
    logic                             accept;
    logic [LEN_W-1:0]                 drop;
    logic [WIN_W-1:0]                 win_shift;

    // Config write port; always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            limit_reg     <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PATTERN_BYTES:      pat_bytes_reg <= cfg.data[WIN_W-1:0];
                CFG_PATTERN_LENGTH:     pat_len_reg   <= cfg.data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg.data[WIN_W-1:0];
                CFG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg.data[LEN_W-1:0];
                CFG_REPLACE_LIMIT:      limit_reg     <= cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated lengths
    assign pl = (pat_len_reg > LEN_W'(PL_CAP)) ? LEN_W'(PL_CAP) : pat_len_reg;
    assign rl = (rep_len_reg > LEN_W'(RL_CAP)) ? LEN_W'(RL_CAP) : rep_len_reg;

    assign in_stream.ready = !q_full;
    assign accept          = in_stream.valid && !q_full;

    // Insert the new byte; a full window overwrites its newest slot
    always_comb
    begin
        fill_eff = (fill_reg >= LEN_W'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH - 1) : fill_reg;
        win_ins  = win_reg;
        win_ins[fill_eff[WIN_IDX_W-1:0]] = in_stream.in_byte;
        fill_ins = fill_eff + LEN_W'(1);
    end

    assign left_start = in_string_reg ? left_reg : limit_reg;
    assign active     = (pl != '0) && (left_start != '0);

    // Parallel compare of the window head against the pattern
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if ((LEN_W'(i) < pl) && (win_ins[i] != pat_bytes_reg[i*BYTE_W +: BYTE_W]))
                match = 1'b0;
        end
    end

    // Decide what this byte sends and how far the window advances
    always_comb
    begin
        q_job.bytes = {{(WIN_W-BYTE_W){1'b0}}, win_ins[0]};
        q_job.count = '0;
        q_job.last  = in_stream.in_last;
        drop        = '0;
        left_next   = left_start;
        if (!in_stream.in_last)
        begin
            if (active && (fill_ins >= pl) && match)
            begin
                q_job.bytes = rep_bytes_reg;
                q_job.count = rl;
                drop        = pl;
                if (left_start > 0)
                    left_next = left_start - LIMIT_W'(1);
            end
            else if (!active || (fill_ins >= pl))
            begin
                q_job.count = LEN_W'(1);
                drop        = LEN_W'(1);
            end
        end
        else
        begin
            if (active && (fill_ins == pl) && match)
            begin
                q_job.bytes = rep_bytes_reg;
                q_job.count = rl;
                if (left_start > 0)
                    left_next = left_start - LIMIT_W'(1);
            end
            else
            begin
                q_job.bytes = win_ins;
                q_job.count = fill_ins;
            end
        end
    end

    assign win_shift = win_ins >> {drop, 3'b000};
    assign win_next  = win_shift;
    assign fill_next = in_stream.in_last ? '0 : (fill_ins - drop);
    assign q_push    = accept && ((q_job.count != '0) || in_stream.in_last);

    // Window state update on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            fill_reg      <= '0;
            left_reg      <= '1;
            in_string_reg <= 1'b0;
        end
        else if (accept)
        begin
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            in_string_reg <= !in_stream.in_last;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_queue.sv -----
// Small job queue between front and back.
`default_nettype none

module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::job_t push_job,
    output logic          full,
    output logic          empty,
    output sfr_pkg::job_t head,
    input  logic          pop
);
    import sfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_back.sv -----
// Back end: expands queued jobs into one result transfer per cycle while the output is not stalled.
`default_nettype none

module sfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  sfr_pkg::job_t q_head,
    output logic          q_pop,
    sfr_out_if.source     out_stream
);
    import sfr_pkg::*;

    logic [WIN_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic                 vbyte_reg;
    logic                 last_reg;

    logic can_load;
    logic take;
    logic job_end;

    assign can_load = !valid_reg || out_stream.ready;
    assign take     = can_load && !q_empty;
    assign job_end  = (q_head.count == '0) ||
                      ({1'b0, idx_reg} == (q_head.count - LEN_W'(1)));
    assign q_pop    = take && job_end;

    // Output register and byte index within the head job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= job_end ? '0 : idx_reg + WIN_IDX_W'(1);
            end
            else if (out_stream.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (q_head.count == '0)
            begin
                byte_reg  <= '0;
                vbyte_reg <= 1'b0;
            end
            else
            begin
                byte_reg  <= q_head.bytes[{idx_reg, 3'b000} +: BYTE_W];
                vbyte_reg <= 1'b1;
            end
            last_reg <= q_head.last && job_end;
        end
    end

    assign out_stream.valid          = valid_reg;
    assign out_stream.out_byte       = byte_reg;
    assign out_stream.out_valid_byte = vbyte_reg;
    assign out_stream.out_last       = last_reg;

endmodule

`default_nettype wire
